### design/bug0_pkg.sv
// ----------------------------------------------------------------------------
// Bug0 motion step package
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package bug0_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int MOVE_WIDTH      = 14;
   localparam int STEP_WIDTH      = 13;
   localparam int DIST_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_GOAL_X        = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_GOAL_Y        = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_STEP_LENGTH   = 2'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_TURN_DISTANCE = 2'd3;

   localparam logic [STEP_WIDTH-1:0] STEP_LENGTH_RESET   = 13'd256;
   localparam logic [DIST_WIDTH-1:0] TURN_DISTANCE_RESET = 16'd256;

   // The larger normalized magnitude lives in [2^29, 2^30).
   localparam int NORM_BITS  = 30;
   localparam int SQ_BITS    = 2 * NORM_BITS + 2;
   localparam int ROOT_BITS  = 31;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = MOVE_WIDTH;
   localparam int CNT_WIDTH  = 5;

   typedef struct packed {
      logic load;
      logic dot1;
      logic dot2;
      logic decide;
      logic norm;
      logic sq1;
      logic sq2;
      logic sqrt_step;
      logic div_load;
      logic div_step;
      logic out_load;
      logic div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic move;
      logic norm_done;
   } dp_status_type;

endpackage

### design/bug0_if.sv
// ----------------------------------------------------------------------------
// Bug0 channel interfaces
// Request channel (robot and obstacle sample) and response channel (move).
// ----------------------------------------------------------------------------
interface bug0_req_if #(
   parameter int COORD_WIDTH = 16
);
   import bug0_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] robot_x;
   logic signed [COORD_WIDTH-1:0] robot_y;
   logic signed [COORD_WIDTH-1:0] obstacle_x;
   logic signed [COORD_WIDTH-1:0] obstacle_y;
   logic        [DIST_WIDTH-1:0]  obstacle_dist;

   modport source (output valid, robot_x, robot_y, obstacle_x, obstacle_y, obstacle_dist,
                   input ready);
   modport sink (input valid, robot_x, robot_y, obstacle_x, obstacle_y, obstacle_dist,
                 output ready);
endinterface

interface bug0_rsp_if;
   import bug0_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [MOVE_WIDTH-1:0] move_dx;
   logic signed [MOVE_WIDTH-1:0] move_dy;
   logic                         mode_now;

   modport source (output valid, move_dx, move_dy, mode_now, input ready);
   modport sink (input valid, move_dx, move_dy, mode_now, output ready);
endinterface

### design/bug0_ctrl.sv
// ----------------------------------------------------------------------------
// Bug0 controller
// Sequences one sample through the datapath and owns the channel handshakes.
// ----------------------------------------------------------------------------
module bug0_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bug0_pkg::dp_status_type status,
   output bug0_pkg::dp_cmd_type   cmd
);
   import bug0_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DOT1   = 4'd1;
   localparam logic [3:0] S_DOT2   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_NORM   = 4'd4;
   localparam logic [3:0] S_SQ1    = 4'd5;
   localparam logic [3:0] S_SQ2    = 4'd6;
   localparam logic [3:0] S_SQRT   = 4'd7;
   localparam logic [3:0] S_DIVXL  = 4'd8;
   localparam logic [3:0] S_DIVX   = 4'd9;
   localparam logic [3:0] S_DIVYL  = 4'd10;
   localparam logic [3:0] S_DIVY   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DOT1;
            end
         end
         S_DOT1: begin
            cmd.dot1 = 1'b1;
            state_in = S_DOT2;
         end
         S_DOT2: begin
            cmd.dot2 = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.move ? S_NORM : S_OUT;
         end
         S_NORM: begin
            if (status.norm_done) begin
               state_in = S_SQ1;
            end else begin
               cmd.norm = 1'b1;
            end
         end
         S_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.sq2  = 1'b1;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(SQRT_STEPS - 1)) begin
               state_in = S_DIVXL;
            end
         end
         S_DIVXL: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIVX;
         end
         S_DIVX: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = S_DIVYL;
            end
         end
         S_DIVYL: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIVY;
         end
         S_DIVY: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // The result register is free once the previous beat has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/bug0_datapath.sv
// ----------------------------------------------------------------------------
// Bug0 datapath
// Configuration registers, mode bit, dot-product sign, normalize shifter,
// serial square root and serial divider for the scaled move.
// ----------------------------------------------------------------------------
module bug0_datapath #(
   parameter int COORD_WIDTH = bug0_pkg::COORD_WIDTH_DEF,
   parameter int CSR_DATA_WIDTH = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [bug0_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]               csr_wdata,
   input  logic signed [COORD_WIDTH-1:0]           robot_x,
   input  logic signed [COORD_WIDTH-1:0]           robot_y,
   input  logic signed [COORD_WIDTH-1:0]           obstacle_x,
   input  logic signed [COORD_WIDTH-1:0]           obstacle_y,
   input  logic [bug0_pkg::DIST_WIDTH-1:0]         obstacle_dist,
   input  bug0_pkg::dp_cmd_type                    cmd,
   output bug0_pkg::dp_status_type                 status,
   output logic signed [bug0_pkg::MOVE_WIDTH-1:0]  move_dx,
   output logic signed [bug0_pkg::MOVE_WIDTH-1:0]  move_dy,
   output logic                                    mode_now
);
   import bug0_pkg::*;

   localparam int VW = COORD_WIDTH + 1;
   localparam int DW = 2 * VW + 1;
   localparam int NW = (COORD_WIDTH > NORM_BITS) ? COORD_WIDTH : NORM_BITS;
   localparam int MW = (VW > NORM_BITS + 1) ? VW : NORM_BITS + 1;
   localparam int NUM_BITS = NORM_BITS + STEP_WIDTH + 1;

   // Configuration and mode.
   logic signed [COORD_WIDTH-1:0] goal_x_ff, goal_y_ff;
   logic [STEP_WIDTH-1:0]         step_ff;
   logic [DIST_WIDTH-1:0]         turn_ff;
   logic                          mode_ff;

   // Per-sample registers.
   logic signed [VW-1:0]   gx_ff, gy_ff, ox_ff, oy_ff;
   logic [DIST_WIDTH-1:0]  dist_ff;
   logic signed [DW-1:0]   dot_ff;
   logic [NW-1:0]          mx_ff, my_ff;
   logic                   sx_ff, sy_ff, move_ff, newmode_ff;
   logic [SQ_BITS-1:0]     sq_ff;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [ROOT_BITS+1:0]   rem_ff;
   logic [ROOT_BITS-1:0]   drem_ff;
   logic [MOVE_WIDTH-1:0]  low_ff, q_ff, qx_ff;
   logic signed [MOVE_WIDTH-1:0] move_dx_ff, move_dy_ff;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic                   dot_neg, dot_pos, go;
   logic signed [VW-1:0]   vx, vy, ax, ay;
   logic [NW-1:0]          m_max;
   logic                   m_small, m_big;
   logic [ROOT_BITS+3:0]   sq_remx, sq_trial;
   logic [NUM_BITS-1:0]    num;
   logic [ROOT_BITS:0]     div_remx;
   logic                   div_ge;
   logic [MOVE_WIDTH-1:0]  lim, qcx, qcy;

   // Shared multiplier; one product per cycle.
   always_comb begin
      mul_a = MW'(gx_ff);
      mul_b = MW'(ox_ff);
      if (cmd.dot2) begin
         mul_a = MW'(gy_ff);
         mul_b = MW'(oy_ff);
      end else if (cmd.sq1) begin
         mul_a = $signed(MW'(mx_ff[NORM_BITS-1:0]));
         mul_b = $signed(MW'(mx_ff[NORM_BITS-1:0]));
      end else if (cmd.sq2) begin
         mul_a = $signed(MW'(my_ff[NORM_BITS-1:0]));
         mul_b = $signed(MW'(my_ff[NORM_BITS-1:0]));
      end else if (cmd.div_load) begin
         mul_a = cmd.div_sel ? $signed(MW'(my_ff[NORM_BITS-1:0]))
                             : $signed(MW'(mx_ff[NORM_BITS-1:0]));
         mul_b = $signed(MW'(step_ff));
      end
   end
   assign prod = mul_a * mul_b;

   // Mode decision from the exact sign of the dot product.
   assign dot_neg = dot_ff[DW-1];
   assign dot_pos = !dot_neg && (dot_ff != '0);
   assign go      = mode_ff ? dot_pos : ((dist_ff > turn_ff) && dot_neg);
   assign vx      = mode_ff ? -oy_ff : gx_ff;
   assign vy      = mode_ff ? ox_ff : gy_ff;
   assign ax      = vx[VW-1] ? -vx : vx;
   assign ay      = vy[VW-1] ? -vy : vy;

   assign m_max   = (mx_ff > my_ff) ? mx_ff : my_ff;
   assign m_small = m_max < NW'(64'd1 << (NORM_BITS - 1));
   assign m_big   = {1'b0, m_max} >= (NW + 1)'(64'd1 << NORM_BITS);

   assign status.move      = go && ((vx != '0) || (vy != '0));
   assign status.norm_done = !m_small && !m_big;

   // One root bit per step from two bits of the radicand.
   assign sq_remx  = {rem_ff, sq_ff[SQ_BITS-1 -: 2]};
   assign sq_trial = (ROOT_BITS + 4)'({root_ff, 2'b01});

   // Rounded numerator and one quotient bit per step.
   assign num      = NUM_BITS'(prod[NORM_BITS+STEP_WIDTH-1:0]) + NUM_BITS'(root_ff >> 1);
   assign div_remx = {drem_ff, low_ff[MOVE_WIDTH-1]};
   assign div_ge   = div_remx >= {1'b0, root_ff};

   assign lim = {1'b0, step_ff};
   assign qcx = (qx_ff > lim) ? lim : qx_ff;
   assign qcy = (q_ff > lim) ? lim : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         step_ff   <= STEP_LENGTH_RESET;
         turn_ff   <= TURN_DISTANCE_RESET;
         mode_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_GOAL_X:        goal_x_ff <= csr_wdata[COORD_WIDTH-1:0];
               REG_GOAL_Y:        goal_y_ff <= csr_wdata[COORD_WIDTH-1:0];
               REG_STEP_LENGTH:   step_ff   <= csr_wdata[STEP_WIDTH-1:0];
               REG_TURN_DISTANCE: turn_ff   <= csr_wdata[DIST_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.out_load) begin
            mode_ff <= newmode_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gx_ff   <= VW'(goal_x_ff) - VW'(robot_x);
         gy_ff   <= VW'(goal_y_ff) - VW'(robot_y);
         ox_ff   <= VW'(obstacle_x) - VW'(robot_x);
         oy_ff   <= VW'(obstacle_y) - VW'(robot_y);
         dist_ff <= obstacle_dist;
      end
      if (cmd.dot1) begin
         dot_ff <= DW'(prod);
      end
      if (cmd.dot2) begin
         dot_ff <= dot_ff + DW'(prod);
      end
      if (cmd.decide) begin
         mx_ff      <= NW'(ax[COORD_WIDTH-1:0]);
         my_ff      <= NW'(ay[COORD_WIDTH-1:0]);
         sx_ff      <= vx[VW-1];
         sy_ff      <= vy[VW-1];
         move_ff    <= status.move;
         newmode_ff <= go ? mode_ff : !mode_ff;
      end
      if (cmd.norm) begin
         // Left shifts are exact; right shifts drop low bits of both.
         if (m_small) begin
            mx_ff <= mx_ff << 1;
            my_ff <= my_ff << 1;
         end else begin
            mx_ff <= mx_ff >> 1;
            my_ff <= my_ff >> 1;
         end
      end
      if (cmd.sq1) begin
         sq_ff <= prod[SQ_BITS-1:0];
      end
      if (cmd.sq2) begin
         sq_ff   <= sq_ff + prod[SQ_BITS-1:0];
         root_ff <= '0;
         rem_ff  <= '0;
      end
      if (cmd.sqrt_step) begin
         sq_ff <= sq_ff << 2;
         if (sq_remx >= sq_trial) begin
            rem_ff  <= (ROOT_BITS + 2)'(sq_remx - sq_trial);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= (ROOT_BITS + 2)'(sq_remx);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
      if (cmd.div_load) begin
         drem_ff <= ROOT_BITS'(num[NUM_BITS-1:MOVE_WIDTH]);
         low_ff  <= num[MOVE_WIDTH-1:0];
         if (cmd.div_sel) begin
            qx_ff <= q_ff;
         end
      end
      if (cmd.div_step) begin
         drem_ff <= div_ge ? ROOT_BITS'(div_remx - {1'b0, root_ff})
                           : ROOT_BITS'(div_remx);
         low_ff  <= low_ff << 1;
         q_ff    <= {q_ff[MOVE_WIDTH-2:0], div_ge};
      end
      if (cmd.out_load) begin
         if (move_ff) begin
            move_dx_ff <= sx_ff ? -$signed(qcx) : $signed(qcx);
            move_dy_ff <= sy_ff ? -$signed(qcy) : $signed(qcy);
         end else begin
            move_dx_ff <= '0;
            move_dy_ff <= '0;
         end
      end
   end

   assign move_dx  = move_dx_ff;
   assign move_dy  = move_dy_ff;
   assign mode_now = mode_ff;

endmodule

### design/bug0_motion_step_unit.sv
// ----------------------------------------------------------------------------
// Bug0 motion step unit
// One reactive obstacle-avoidance move per robot control tick.
// ----------------------------------------------------------------------------
// Usage: a beat on req_chan carries the robot position, the nearest obstacle
// point and its distance. Each request beat yields exactly one beat on
// rsp_chan with the commanded move and the mode after the step. Goal, step
// length and turn distance are to be written on the csr_ port only while the
// unit is idle; the unit itself does not enforce this. Requests are taken one
// at a time: req_chan.ready is high only while no sample is in work. A zero
// move skips the normalize, square root and divide steps. A nonzero move goes
// through the one-bit-per-cycle normalize shifter, the serial square root and
// two serial divisions that share one multiplier. The result sits in an
// output register, so a new request is taken while it waits; if the
// receiver still stalls when the next result is done, the unit holds it.
// Reset clears the mode to straight and loads the register defaults: goal
// at the origin, step length and turn distance of 1.0.
// ----------------------------------------------------------------------------
module bug0_motion_step_unit #(
   parameter int COORD_WIDTH = bug0_pkg::COORD_WIDTH_DEF,
   parameter int CSR_DATA_WIDTH = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
   input  logic                                clock,
   input  logic                                reset,
   bug0_req_if.sink                            req_chan,
   bug0_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [bug0_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]           csr_wdata
);
   import bug0_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bug0_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bug0_datapath #(
      .COORD_WIDTH    (COORD_WIDTH),
      .CSR_DATA_WIDTH (CSR_DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .robot_x       (req_chan.robot_x),
      .robot_y       (req_chan.robot_y),
      .obstacle_x    (req_chan.obstacle_x),
      .obstacle_y    (req_chan.obstacle_y),
      .obstacle_dist (req_chan.obstacle_dist),
      .cmd           (cmd),
      .status        (status),
      .move_dx       (rsp_chan.move_dx),
      .move_dy       (rsp_chan.move_dy),
      .mode_now      (rsp_chan.mode_now)
   );

`ifndef NO_ASSERTIONS
   // Only one sample is in work at a time.
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while a sample is in work");

   // A result is never written over one that has not been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // The controller issues at most one datapath operation per cycle.
   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.dot1, cmd.dot2, cmd.decide, cmd.norm, cmd.sq1,
                cmd.sq2, cmd.sqrt_step, cmd.div_load, cmd.div_step, cmd.out_load}))
      else $error("more than one datapath operation");

   // A new result appears only when one was loaded.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.out_load))
      else $error("response beat without a loaded result");
`endif

endmodule
